>>> rtl/pfd_pkg.sv
// Shared types and constants for the pose frame deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package pfd_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned PAY_LEN  = 12;
  localparam int unsigned IDX_W    = 4;

  localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h0D;
  localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h0A;
  localparam logic [BYTE_W-1:0] TRL_FIRST  = 8'h0A;
  localparam logic [BYTE_W-1:0] TRL_SECOND = 8'h0D;

  localparam logic [IDX_W-1:0]  IDX_LAST   = IDX_W'(PAY_LEN);

  typedef struct packed {
    logic              vld;
    logic [BYTE_W-1:0] data;
  } pfd_byte_t;

endpackage

`default_nettype wire

>>> rtl/pfd_in_reg.sv
// Input register for received bytes: holds one byte until the parser takes it.
// Depends on pfd_pkg for the byte bundle type.
`default_nettype none

module pfd_in_reg
  import pfd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] in_rx_byte,
  output pfd_byte_t              byte_o,
  input  wire logic              take_i
);

  logic              vld_r, vld_nxt;
  logic [BYTE_W-1:0] data_r;
  logic              load;

  assign in_ready = !vld_r || take_i;
  assign load     = in_valid && in_ready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (take_i) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= in_rx_byte;
    end
  end

  assign byte_o = '{vld: vld_r, data: data_r};

endmodule

`default_nettype wire

>>> rtl/pfd_parser.sv
// Frame parser: header/trailer state machine, payload store and result register.
// Depends on pfd_pkg for constants and the byte bundle type.
`default_nettype none

module pfd_parser
  import pfd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  pfd_byte_t              byte_i,
  output logic                   take_o,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [WORD_W-1:0]      out_angle_word,
  output logic [WORD_W-1:0]      out_x_word,
  output logic [WORD_W-1:0]      out_y_word
);

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_HDR2 = 3'd1;
  localparam logic [2:0] PH_DATA = 3'd2;
  localparam logic [2:0] PH_TRL1 = 3'd3;
  localparam logic [2:0] PH_TRL2 = 3'd4;

  logic [2:0]        phase_r, phase_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [IDX_W-1:0]  idx_inc;
  logic              out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0] angle_r, x_r, y_r;
  logic [BYTE_W-1:0] store_r [PAY_LEN];
  logic              last_byte;
  logic              emit;
  logic              wr_en;

  assign last_byte = byte_i.vld && (phase_r == PH_TRL2) && (byte_i.data == TRL_SECOND);
  assign take_o    = byte_i.vld && !(last_byte && out_valid_r && !out_ready);
  assign wr_en     = take_o && (phase_r == PH_DATA) && (idx_r < IDX_LAST);
  assign emit      = take_o && last_byte;

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    idx_inc   = idx_r;
    if (take_o) begin
      case (phase_r)
        PH_HUNT: begin
          phase_nxt = (byte_i.data == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
        end
        PH_HDR2: begin
          if (byte_i.data == HDR_SECOND) begin
            idx_nxt   = '0;
            phase_nxt = PH_DATA;
          end else if (byte_i.data != HDR_FIRST) begin
            phase_nxt = PH_HUNT;
          end
        end
        PH_DATA: begin
          if (idx_r < IDX_LAST) begin
            idx_inc = idx_r + IDX_W'(1);
          end
          idx_nxt = idx_inc;
          if (idx_inc >= IDX_LAST) begin
            idx_nxt   = '0;
            phase_nxt = PH_TRL1;
          end
        end
        PH_TRL1: begin
          phase_nxt = (byte_i.data == TRL_FIRST) ? PH_TRL2 : PH_HUNT;
        end
        PH_TRL2: begin
          phase_nxt = PH_HUNT;
        end
        default: begin
          phase_nxt = PH_HUNT;
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[idx_r] <= byte_i.data;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      angle_r <= {store_r[3], store_r[2], store_r[1], store_r[0]};
      x_r     <= {store_r[7], store_r[6], store_r[5], store_r[4]};
      y_r     <= {store_r[11], store_r[10], store_r[9], store_r[8]};
    end
  end

  assign out_valid      = out_valid_r;
  assign out_angle_word = angle_r;
  assign out_x_word     = x_r;
  assign out_y_word     = y_r;

  a_emit_after_trl2: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (phase_r == PH_TRL2) && (byte_i.data == TRL_SECOND))
    else $error("result without complete trailer");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r < IDX_LAST)
    else $error("payload index out of range");

  a_trl1_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (take_o && phase_r == PH_TRL1) |=> (phase_r == PH_TRL2) || (phase_r == PH_HUNT))
    else $error("bad exit from first trailer byte");

  a_data_to_trl: assert property (@(posedge clk) disable iff (!rst_n)
    (take_o && phase_r == PH_DATA && phase_nxt == PH_TRL1)
      |-> (idx_r == IDX_LAST - IDX_W'(1)))
    else $error("payload ended early");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (last_byte && out_valid_r && !out_ready) |=> $stable(phase_r) && $stable(idx_r))
    else $error("parser advanced while result stalled");

endmodule

`default_nettype wire

>>> rtl/pose_frame_deframer.sv
// Pose frame deframer: takes one received byte per word on the in_ channel and
// finds frames 0D 0A, 12 payload bytes, 0A 0D (extra 0D after the first header
// byte allowed). A complete frame yields one out_ word: angle, x and y, each
// four payload bytes little-endian. One byte is taken every cycle unless intake
// is stalled; a result appears on out_ after its last trailer byte has passed
// the input register and the parser has then loaded the result register.
// Intake stalls only when a completing byte meets a result register still
// waiting on out_ready.
// Depends on pfd_pkg, pfd_in_reg and pfd_parser.
`default_nettype none

module pose_frame_deframer
  import pfd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [BYTE_W-1:0] in_rx_byte,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [WORD_W-1:0]      out_angle_word,
  output logic [WORD_W-1:0]      out_x_word,
  output logic [WORD_W-1:0]      out_y_word
);

  pfd_byte_t byte_s;
  logic      take_s;

  pfd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .byte_o     (byte_s),
    .take_i     (take_s)
  );

  pfd_parser u_parser (
    .clk            (clk),
    .rst_n          (rst_n),
    .byte_i         (byte_s),
    .take_o         (take_s),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_angle_word (out_angle_word),
    .out_x_word     (out_x_word),
    .out_y_word     (out_y_word)
  );

endmodule

`default_nettype wire
